// File: rtl/ddet_pkg.sv
// ----------------------------------------------------------------------------
// ddet_pkg
// Shared codes, field widths and control structs of the deadlock detector.
// ----------------------------------------------------------------------------
package ddet_pkg;

  localparam int CMD_W      = 2;
  localparam int PROC_ID_W  = 4;
  localparam int RES_ID_W   = 3;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int PC_FIELD_W = 5;
  localparam int RC_FIELD_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_EXISTING = 2'd0,
    CMD_ALLOC    = 2'd1,
    CMD_REQUEST  = 2'd2,
    CMD_RUN      = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROC_COUNT = 2'd0,
    CFG_RES_COUNT  = 2'd1
  } cfg_idx_t;

  // write enables of the matrix store
  typedef struct packed {
    logic alloc;
    logic req;
  } store_we_t;

  // top level to sequencer
  typedef struct packed {
    logic start;
    logic exist_we;
  } seq_ctrl_t;

  // sequencer to top level
  typedef struct packed {
    logic idle;
  } seq_stat_t;

endpackage

// File: rtl/ddet_if.sv
// ----------------------------------------------------------------------------
// ddet_if
// Valid/ready channels: command items in, per-process result items out.
// ----------------------------------------------------------------------------
interface ddet_cmd_if
  import ddet_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [PROC_ID_W-1:0] proc_id;
  logic [RES_ID_W-1:0]  res_id;
  logic [COUNT_W-1:0]   count;

  modport source (output valid, cmd, proc_id, res_id, count, input ready);
  modport sink   (input valid, cmd, proc_id, res_id, count, output ready);
endinterface

interface ddet_res_if
  import ddet_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [PROC_ID_W-1:0] proc_out;
  logic                 deadlocked;
  logic                 any_deadlock;
  logic                 last;

  modport source (output valid, proc_out, deadlocked, any_deadlock, last, input ready);
  modport sink   (input valid, proc_out, deadlocked, any_deadlock, last, output ready);
endinterface

// File: rtl/ddet_store.sv
// ----------------------------------------------------------------------------
// ddet_store
// Allocation and request matrices, one synchronous RAM each, shared address.
// ----------------------------------------------------------------------------
module ddet_store
  import ddet_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  store_we_t     we,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] alloc_q,
  output logic [DW-1:0] req_q
);

  logic [DW-1:0] alloc_mem [DEPTH];
  logic [DW-1:0] req_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (we.alloc) begin
      alloc_mem[wr_addr] <= wr_data;
    end
    alloc_q <= alloc_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we.req) begin
      req_mem[wr_addr] <= wr_data;
    end
    req_q <= req_mem[rd_addr];
  end

endmodule

// File: rtl/ddet_seq.sv
// ----------------------------------------------------------------------------
// ddet_seq
// Run sequencer: available counts, finished marks, scan passes, result items.
// ----------------------------------------------------------------------------
module ddet_seq
  import ddet_pkg::*;
#(
  parameter int MAX_PROCS  = 16,
  parameter int MAX_RES    = 8,
  parameter int COUNT_BITS = 16,
  parameter int AW         = 7,
  parameter int PIW        = 4,
  parameter int RIW        = 3,
  parameter int PCW        = 5,
  parameter int RCW        = 4,
  parameter int AVAIL_W    = 21
) (
  input  logic                  clk,
  input  logic                  rst,
  input  seq_ctrl_t             ctrl,
  output seq_stat_t             stat,
  input  logic [RIW-1:0]        exist_idx,
  input  logic [COUNT_BITS-1:0] exist_data,
  input  logic [PCW-1:0]        proc_count,
  input  logic [RCW-1:0]        res_count,
  output logic [AW-1:0]         rd_addr,
  input  logic [COUNT_BITS-1:0] alloc_q,
  input  logic [COUNT_BITS-1:0] req_q,
  ddet_res_if.source            res
);

  typedef enum logic [3:0] {
    IDLE, INIT, SUB_RD, SUB_UPD, SCAN, CHK_RD, CHK_CMP, ADD_RD, ADD_UPD, ADV, EMIT
  } state_t;

  state_t                      state;
  logic [COUNT_BITS-1:0]       existing [MAX_RES];
  logic signed [AVAIL_W-1:0]   avail [MAX_RES];
  logic [MAX_PROCS-1:0]        finished;
  logic [PIW-1:0]              p;
  logic [RIW-1:0]              r;
  logic                        progress;

  logic                        p_last;
  logic                        r_last;
  logic                        any_comb;
  logic signed [AVAIL_W-1:0]   alloc_ext;
  logic signed [AVAIL_W-1:0]   req_ext;
  logic [PIW-1:0]              p_inc;

  assign p_last    = (32'(p) + 32'd1 == 32'(proc_count));
  assign r_last    = (32'(r) + 32'd1 == 32'(res_count));
  assign p_inc     = PIW'(32'(p) + 32'd1);
  assign alloc_ext = $signed({{(AVAIL_W-COUNT_BITS){1'b0}}, alloc_q});
  assign req_ext   = $signed({{(AVAIL_W-COUNT_BITS){1'b0}}, req_q});
  assign rd_addr   = AW'(32'(p) * MAX_RES + 32'(r));
  assign stat.idle = (state == IDLE);

  always_comb begin
    any_comb = 1'b0;
    for (int i = 0; i < MAX_PROCS; i++) begin
      if (!finished[i] && (i < 32'(proc_count))) begin
        any_comb = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exist_we) begin
      existing[exist_idx] <= exist_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      finished  <= '0;
      progress  <= 1'b0;
      p         <= '0;
      r         <= '0;
      res.valid <= 1'b0;
      for (int i = 0; i < MAX_RES; i++) begin
        avail[i] <= '0;
      end
    end else begin
      case (state)
        IDLE: begin
          if (ctrl.start) begin
            state <= INIT;
          end
        end
        INIT: begin
          for (int i = 0; i < MAX_RES; i++) begin
            avail[i] <= $signed({{(AVAIL_W-COUNT_BITS){1'b0}}, existing[i]});
          end
          finished <= '0;
          progress <= 1'b0;
          p        <= '0;
          r        <= '0;
          state    <= SUB_RD;
        end
        // available = existing minus every allocation in use
        SUB_RD: state <= SUB_UPD;
        SUB_UPD: begin
          avail[r] <= avail[r] - alloc_ext;
          if (r_last) begin
            r <= '0;
            if (p_last) begin
              p     <= '0;
              state <= SCAN;
            end else begin
              p     <= p_inc;
              state <= SUB_RD;
            end
          end else begin
            r     <= RIW'(32'(r) + 32'd1);
            state <= SUB_RD;
          end
        end
        SCAN: begin
          r     <= '0;
          state <= finished[p] ? ADV : CHK_RD;
        end
        CHK_RD: state <= CHK_CMP;
        CHK_CMP: begin
          if (req_ext > avail[r]) begin
            state <= ADV;
          end else if (r_last) begin
            r     <= '0;
            state <= ADD_RD;
          end else begin
            r     <= RIW'(32'(r) + 32'd1);
            state <= CHK_RD;
          end
        end
        ADD_RD: state <= ADD_UPD;
        ADD_UPD: begin
          avail[r] <= avail[r] + alloc_ext;
          if (r_last) begin
            finished[p] <= 1'b1;
            progress    <= 1'b1;
            state       <= ADV;
          end else begin
            r     <= RIW'(32'(r) + 32'd1);
            state <= ADD_RD;
          end
        end
        ADV: begin
          if (!p_last) begin
            p     <= p_inc;
            state <= SCAN;
          end else if (progress) begin
            progress <= 1'b0;
            p        <= '0;
            state    <= SCAN;
          end else begin
            p                <= '0;
            res.valid        <= 1'b1;
            res.proc_out     <= '0;
            res.deadlocked   <= !finished[0];
            res.any_deadlock <= any_comb;
            res.last         <= (32'(proc_count) == 32'd1);
            state            <= EMIT;
          end
        end
        EMIT: begin
          if (res.ready) begin
            if (res.last) begin
              res.valid <= 1'b0;
              state     <= IDLE;
            end else begin
              p              <= p_inc;
              res.proc_out   <= PROC_ID_W'(32'(p) + 32'd1);
              res.deadlocked <= !finished[p_inc];
              res.last       <= (32'(p) + 32'd2 == 32'(proc_count));
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: rtl/deadlock_detector_core.sv
// ----------------------------------------------------------------------------
// deadlock_detector_core
// Multi-resource deadlock detection over allocation and request matrices.
// ----------------------------------------------------------------------------
//  channel    | dir | handshake   | payload
//  cmd_ch     | in  | valid/ready | cmd, proc_id, res_id, count
//  result_ch  | out | valid/ready | proc_out, deadlocked, any_deadlock, last
//  cfg        | in  | cfg_we      | cfg_index, cfg_data
//
//  Load items are taken whenever the core is idle. A run item holds ready low
//  until its last result item is taken: setup and subtraction after the item
//  is taken, then scan passes (at most P+1 passes), then one result item per
//  process, P = proc_count. Each matrix RAM has a single read port, and both
//  share one read address. Reset is synchronous and holds ready low; no
//  clearing pass. A stalled result item holds; the run resumes when it is taken.
// ----------------------------------------------------------------------------
module deadlock_detector_core
  import ddet_pkg::*;
#(
  parameter int MAX_PROCS  = 16,
  parameter int MAX_RES    = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  ddet_cmd_if.sink              cmd_ch,
  ddet_res_if.source            result_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH   = MAX_PROCS * MAX_RES;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PIW     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RIW     = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int PCW     = $clog2(MAX_PROCS + 1);
  localparam int RCW     = $clog2(MAX_RES + 1);
  localparam int AVAIL_W = COUNT_BITS + $clog2(MAX_PROCS + 1) + 1;
  localparam int PC_RST  = (MAX_PROCS < 16) ? MAX_PROCS : 16;
  localparam int RC_RST  = (MAX_RES < 8) ? MAX_RES : 8;

  logic [PCW-1:0]        proc_count;
  logic [RCW-1:0]        res_count;
  logic [PC_FIELD_W-1:0] pc_val;
  logic [RC_FIELD_W-1:0] rc_val;

  assign pc_val = cfg_data[PC_FIELD_W-1:0];
  assign rc_val = cfg_data[RC_FIELD_W-1:0];

  // counts saturate into 1..max
  always_ff @(posedge clk) begin
    if (rst) begin
      proc_count <= PCW'(PC_RST);
      res_count  <= RCW'(RC_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROC_COUNT: begin
          if (pc_val == '0) begin
            proc_count <= PCW'(1);
          end else if (32'(pc_val) > MAX_PROCS) begin
            proc_count <= PCW'(MAX_PROCS);
          end else begin
            proc_count <= PCW'(pc_val);
          end
        end
        CFG_RES_COUNT: begin
          if (rc_val == '0) begin
            res_count <= RCW'(1);
          end else if (32'(rc_val) > MAX_RES) begin
            res_count <= RCW'(MAX_RES);
          end else begin
            res_count <= RCW'(rc_val);
          end
        end
        default: ;
      endcase
    end
  end

  seq_ctrl_t             ctrl;
  seq_stat_t             stat;
  store_we_t             we;
  logic                  accept;
  logic                  rid_ok;
  logic                  pid_ok;
  logic [COUNT_BITS+15:0] cnt_wide;
  logic [COUNT_BITS-1:0] cnt;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [COUNT_BITS-1:0] alloc_q;
  logic [COUNT_BITS-1:0] req_q;

  assign cmd_ch.ready = stat.idle && !rst;
  assign accept       = cmd_ch.valid && cmd_ch.ready;
  assign rid_ok       = (32'(cmd_ch.res_id) < MAX_RES);
  assign pid_ok       = (32'(cmd_ch.proc_id) < MAX_PROCS);
  assign cnt_wide     = {{COUNT_BITS{1'b0}}, cmd_ch.count};
  assign cnt          = cnt_wide[COUNT_BITS-1:0];
  assign wr_addr      = AW'(32'(cmd_ch.proc_id) * MAX_RES + 32'(cmd_ch.res_id));

  assign ctrl.start    = accept && (cmd_ch.cmd == CMD_RUN);
  assign ctrl.exist_we = accept && (cmd_ch.cmd == CMD_EXISTING) && rid_ok;
  assign we.alloc      = accept && (cmd_ch.cmd == CMD_ALLOC) && rid_ok && pid_ok;
  assign we.req        = accept && (cmd_ch.cmd == CMD_REQUEST) && rid_ok && pid_ok;

  ddet_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (COUNT_BITS)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (cnt),
    .rd_addr (rd_addr),
    .alloc_q (alloc_q),
    .req_q   (req_q)
  );

  ddet_seq #(
    .MAX_PROCS  (MAX_PROCS),
    .MAX_RES    (MAX_RES),
    .COUNT_BITS (COUNT_BITS),
    .AW         (AW),
    .PIW        (PIW),
    .RIW        (RIW),
    .PCW        (PCW),
    .RCW        (RCW),
    .AVAIL_W    (AVAIL_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .exist_idx  (RIW'(cmd_ch.res_id)),
    .exist_data (cnt),
    .proc_count (proc_count),
    .res_count  (res_count),
    .rd_addr    (rd_addr),
    .alloc_q    (alloc_q),
    .req_q      (req_q),
    .res        (result_ch)
  );

endmodule
